// ===== rtl/core/oldk_pkg.sv =====
// Package for the ordered list unit: sizes, operation and status codes,
// transfer structs and the cell control struct. No dependencies.

package oldk_pkg;

  localparam int DEPTH       = 16;
  localparam int KeyW        = 16;
  localparam int CntW        = $clog2(DEPTH + 1);
  localparam int EntryCountW = 5;

  localparam logic [1:0] OP_FRONT  = 2'd0;
  localparam logic [1:0] OP_BACK   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]      operation;
    logic [KeyW-1:0] item_key;
  } cmd_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [KeyW-1:0]        entry_value;
    logic [EntryCountW-1:0] entry_count;
    logic                   last_of_run;
  } rsp_t;

  typedef enum logic [2:0] {
    CC_HOLD,
    CC_PUSH_FRONT,
    CC_PUSH_BACK,
    CC_REMOVE,
    CC_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t       cmd;
    logic [KeyW-1:0] key;
  } cell_ctl_t;

endpackage

// ===== rtl/core/oldk_cell.sv =====
// One storage cell of the ordered list chain: holds one identifier,
// compares it with the key and shifts toward either neighbor. Uses oldk_pkg.

module oldk_cell
  import oldk_pkg::*;
(
  input  logic            clk,
  input  cell_ctl_t       ctl,
  input  logic            occ,
  input  logic            at_back,
  input  logic            at_tail,
  input  logic            hit_in,
  input  logic [KeyW-1:0] left_val,
  input  logic [KeyW-1:0] right_val,
  input  logic [KeyW-1:0] head_val,
  output logic [KeyW-1:0] val,
  output logic            hit_out
);

  logic [KeyW-1:0] val_next;

  // hit_out: a match sits in this cell or somewhere in front of it
  assign hit_out = hit_in | (occ & (val == ctl.key));

  always_comb begin
    val_next = val;
    case (ctl.cmd)
      CC_PUSH_FRONT: val_next = left_val;
      CC_PUSH_BACK:  if (at_back) val_next = ctl.key;
      CC_REMOVE:     if (hit_out) val_next = right_val;
      CC_ROTATE:     val_next = at_tail ? head_val : right_val;
      default:       val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ===== rtl/core/ordered_list_with_delete_by_key_unit.sv =====
// Top level of the ordered list unit: control, fill count, output register
// and the chain of oldk_cell instances. Uses oldk_pkg.
//
// Usage:
//   Command channel (cmd_valid / cmd_stall / cmd) carries an operation and a
//   key; a transfer happens when cmd_valid is high and cmd_stall is low.
//   Response channel (rsp_valid / rsp_stall / rsp) returns results from a
//   single output register; a stalled response holds until taken.
//   Insert front, insert back and remove each give one result, registered
//   on the transfer edge. Insert front shifts every cell toward the back;
//   remove shifts every cell behind the first match toward the front,
//   both in the same cycle.
//   Read all gives N results for N entries (one empty result when N is 0),
//   front to back: cell 0 is emitted while the chain rotates by one, so after
//   N rotations the order is back as before. New commands wait until the
//   run is done and the output register is free.
//   A stalled response stalls the command channel as well.
//   Synchronous reset empties the list and drops any pending response.

module ordered_list_with_delete_by_key_unit
  import oldk_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t          state, state_next;
  logic [CntW-1:0] count, count_next;
  logic [CntW-1:0] rem, rem_next;
  rsp_t            rsp_next;
  logic            load;
  logic            out_free;
  logic            take;
  logic            full;
  cell_ctl_t       ctl;

  logic [KeyW-1:0] val [DEPTH];
  logic [DEPTH:0]  hit;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = (state != S_IDLE) || !out_free;
  assign take      = cmd_valid && !cmd_stall;
  assign full      = (count == CntW'(DEPTH));
  assign hit[0]    = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KeyW-1:0] left_val;
    logic [KeyW-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = cmd.item_key;
    end else begin : g_mid
      assign left_val = val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = val[0];
    end else begin : g_inner
      assign right_val = val[i+1];
    end

    oldk_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (CntW'(i) < count),
      .at_back   (CntW'(i) == count),
      .at_tail   (CntW'(i) == count - CntW'(1)),
      .hit_in    (hit[i]),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (val[0]),
      .val       (val[i]),
      .hit_out   (hit[i+1])
    );
  end

  always_comb begin
    state_next = state;
    count_next = count;
    rem_next   = rem;
    rsp_next   = rsp;
    load       = 1'b0;
    ctl.cmd    = CC_HOLD;
    ctl.key    = cmd.item_key;

    if (take) begin
      load                 = 1'b1;
      rsp_next.status      = ST_OK;
      rsp_next.entry_value = cmd.item_key;
      rsp_next.last_of_run = 1'b1;
      case (cmd.operation)
        OP_FRONT, OP_BACK: begin
          if (full) begin
            rsp_next.status = ST_FULL;
          end else begin
            ctl.cmd    = (cmd.operation == OP_FRONT) ? CC_PUSH_FRONT : CC_PUSH_BACK;
            count_next = count + CntW'(1);
          end
        end
        OP_REMOVE: begin
          if (count == '0) begin
            rsp_next.status = ST_EMPTY;
          end else if (!hit[DEPTH]) begin
            rsp_next.status = ST_MISSING;
          end else begin
            ctl.cmd    = CC_REMOVE;
            count_next = count - CntW'(1);
          end
        end
        default: begin
          if (count == '0) begin
            rsp_next.status      = ST_EMPTY;
            rsp_next.entry_value = '0;
          end else begin
            ctl.cmd              = CC_ROTATE;
            rsp_next.entry_value = val[0];
            rsp_next.last_of_run = (count == CntW'(1));
            if (count != CntW'(1)) begin
              state_next = S_READ;
              rem_next   = count - CntW'(1);
            end
          end
        end
      endcase
      rsp_next.entry_count = EntryCountW'(count_next);
    end else if (state == S_READ && out_free) begin
      load                 = 1'b1;
      ctl.cmd              = CC_ROTATE;
      rsp_next.status      = ST_OK;
      rsp_next.entry_value = val[0];
      rsp_next.entry_count = EntryCountW'(count);
      rsp_next.last_of_run = (rem == CntW'(1));
      rem_next             = rem - CntW'(1);
      if (rem == CntW'(1)) begin
        state_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rem       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rem   <= rem_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("fill count above depth");

  a_read_blocks_cmd: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> cmd_stall)
    else $error("command taken during read run");

  a_read_remaining: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (rem != '0 && rem < count))
    else $error("read run counter out of range");

  a_count_stable_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (count == $past(count)))
    else $error("fill count changed during read run");

endmodule

// ===== tb/ordered_list_with_delete_by_key_unit_tb.sv =====
// Testbench for ordered_list_with_delete_by_key_unit: directed and random
// command streams checked against a queue-based shadow of the list.
// Depends on oldk_pkg and the unit itself.
`timescale 1ns / 100ps

module ordered_list_with_delete_by_key_unit_tb;
  import oldk_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 40;

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  logic [KeyW-1:0] shadow_keys[$];
  rsp_t            awaited_rsp[$];
  int              error_count = 0;
  int              cycle_count = 0;
  bit              cmd_idling  = 1'b0;
  bit              rsp_idling  = 1'b0;
  bit              long_hold_req = 1'b0;

  ordered_list_with_delete_by_key_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #6 clk = ~clk;

  // Shadow list update: queues the results one command should produce.
  function automatic void apply_list_op(cmd_t c);
    rsp_t r;
    int   hit;
    r = '0;
    r.entry_value = c.item_key;
    r.last_of_run = 1'b1;
    hit = -1;
    case (c.operation)
      OP_FRONT, OP_BACK: begin
        if (shadow_keys.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (c.operation == OP_FRONT) shadow_keys.push_front(c.item_key);
          else shadow_keys.push_back(c.item_key);
          r.status = ST_OK;
        end
        r.entry_count = EntryCountW'(shadow_keys.size());
        awaited_rsp.push_back(r);
      end
      OP_REMOVE: begin
        foreach (shadow_keys[i])
          if (hit < 0 && shadow_keys[i] == c.item_key) hit = i;
        if (shadow_keys.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (hit < 0) begin
          r.status = ST_MISSING;
        end else begin
          shadow_keys.delete(hit);
          r.status = ST_OK;
        end
        r.entry_count = EntryCountW'(shadow_keys.size());
        awaited_rsp.push_back(r);
      end
      default: begin
        if (shadow_keys.size() == 0) begin
          r.status      = ST_EMPTY;
          r.entry_value = '0;
          awaited_rsp.push_back(r);
        end else begin
          foreach (shadow_keys[i]) begin
            r.status      = ST_OK;
            r.entry_value = shadow_keys[i];
            r.entry_count = EntryCountW'(shadow_keys.size());
            r.last_of_run = (i == shadow_keys.size() - 1);
            awaited_rsp.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // One command transfer, with an optional idle burst in front of it.
  task automatic send_item(logic [1:0] op, logic [KeyW-1:0] key);
    cmd_t c;
    c.operation = op;
    c.item_key  = key;
    if (cmd_idling && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall !== 1'b0) @(posedge clk);
    apply_list_op(c);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_item(OP_READ, 16'h0000);
    send_item(OP_REMOVE, 16'hFFFF);
  endtask

  task automatic test_insert_remove();
    send_item(OP_FRONT, 16'h0000);
    send_item(OP_BACK, 16'hFFFF);
    send_item(OP_FRONT, 16'h8000);
    send_item(OP_BACK, 16'h7FFF);
    send_item(OP_BACK, 16'h1234);
    send_item(OP_BACK, 16'h1234);
    send_item(OP_FRONT, 16'h1234);
    send_item(OP_READ, 16'hA5A5);
    send_item(OP_REMOVE, 16'h1234);
    send_item(OP_REMOVE, 16'h5555);
    send_item(OP_READ, 16'h0000);
  endtask

  task automatic test_full_list();
    while (shadow_keys.size() < DEPTH) send_item(OP_BACK, KeyW'($urandom()));
    send_item(OP_FRONT, 16'hDEAD);
    send_item(OP_BACK, 16'hBEEF);
    send_item(OP_READ, 16'h0000);
    send_item(OP_REMOVE, shadow_keys[DEPTH/2]);
    send_item(OP_REMOVE, shadow_keys[0]);
    send_item(OP_REMOVE, shadow_keys[shadow_keys.size() - 1]);
  endtask

  // Receiver holds off while commands keep coming, then the sender pauses.
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    repeat (6) send_item(OP_FRONT, KeyW'($urandom()));
    send_item(OP_READ, 16'h0000);
    send_item(OP_REMOVE, KeyW'($urandom()));
    wait_drained();
  endtask

  task automatic test_random_traffic(int batches, int per_batch);
    int               r;
    bit               fill_bias;
    logic [1:0]       op;
    logic [KeyW-1:0]  key;
    for (int b = 0; b < batches; b++) begin
      fill_bias  = $urandom_range(0, 1);
      cmd_idling = (b < batches - 1) && $urandom_range(0, 3) != 0;
      rsp_idling = (b < batches - 1) && $urandom_range(0, 3) != 0;
      for (int n = 0; n < per_batch; n++) begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) key = KeyW'($urandom_range(0, 7));
        else key = KeyW'($urandom());
        if (r < (fill_bias ? 35 : 20)) begin
          op = OP_FRONT;
        end else if (r < (fill_bias ? 70 : 40)) begin
          op = OP_BACK;
        end else if (r < 92) begin
          op = OP_REMOVE;
          if (shadow_keys.size() != 0 && $urandom_range(0, 9) < 7)
            key = shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
        end else begin
          op = OP_READ;
        end
        send_item(op, key);
      end
    end
  endtask

  // Response stall generator: random bursts, or one long hold on request.
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        rsp_stall <= 1'b0;
      end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (awaited_rsp.size() == 0) begin
        $display("%0t: unexpected response %p", $realtime, rsp);
        error_count++;
      end else begin
        exp_rsp = awaited_rsp.pop_front();
        if (rsp.status !== exp_rsp.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $realtime, exp_rsp.status, rsp.status);
          error_count++;
        end
        if (rsp.entry_value !== exp_rsp.entry_value) begin
          $display("%0t: entry_value expected %h actual %h",
                   $realtime, exp_rsp.entry_value, rsp.entry_value);
          error_count++;
        end
        if (rsp.entry_count !== exp_rsp.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $realtime, exp_rsp.entry_count, rsp.entry_count);
          error_count++;
        end
        if (rsp.last_of_run !== exp_rsp.last_of_run) begin
          $display("%0t: last_of_run expected %b actual %b",
                   $realtime, exp_rsp.last_of_run, rsp.last_of_run);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_insert_remove();
    test_full_list();
    test_backpressure();
    test_random_traffic(8, 15);
    cmd_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== ordered_list_with_delete_by_key_unit.f =====
rtl/core/oldk_pkg.sv
rtl/core/oldk_cell.sv
rtl/core/ordered_list_with_delete_by_key_unit.sv
tb/ordered_list_with_delete_by_key_unit_tb.sv
